// ===== hw/rtl/sfid_pkg.sv =====
package sfid_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int PHASE_BITS     = 32;
    localparam int START_BITS     = 16;
    localparam int DEPTH_BITS     = 19;
    localparam int GAIN_BITS      = 16;
    localparam int SINE_BITS      = 16;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;

    // depth * (32768 + sine) >> 15 keeps one more bit than depth
    localparam int TAU_BITS  = DEPTH_BITS + 1;
    // 256*s0 + frac*(s1 - s0)
    localparam int ACC_BITS  = SAMPLE_BITS + 10;
    localparam int WET_PROD_BITS = ACC_BITS + GAIN_BITS + 1;
    localparam int WET_SHIFT = 23;
    localparam int WET_BITS  = WET_PROD_BITS - WET_SHIFT;
    localparam int SUM_BITS  = WET_BITS + 1;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 32'd22370;
    localparam logic [START_BITS-1:0] START_PHASE_RESET = 16'd0;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 19'd24000;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd32768;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // sine table generation, Q28 Taylor series
    localparam longint TWO_PI_Q28 = 64'sd1686629713;
    localparam longint Q28_ONE    = 64'sd268435456;
    localparam longint Q15_DIV    = 64'sd8192;
    localparam longint Q15_HALF   = 64'sd4096;
    localparam longint SINE_HI    = 64'sd32767;
    localparam longint SINE_LO    = -64'sd32768;
    localparam int TAYLOR_TERMS   = 10;
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110,
          64'sd156, 64'sd210, 64'sd272, 64'sd342, 64'sd420};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_START_PHASE = 2'd1,
        CFG_DEPTH       = 2'd2,
        CFG_GAIN        = 2'd3
    } sfid_cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } sfid_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } sfid_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAU,
        S_ADDR,
        S_RD0,
        S_RD1,
        S_ACC,
        S_GAIN,
        S_MIX
    } sfid_state_t;

    typedef struct packed {
        logic accept;
        logic calc_tau;
        logic calc_addr;
        logic rd_second;
        logic latch_s0;
        logic calc_acc;
        logic calc_gain;
        logic load_out;
    } sfid_cmd_t;

    // angle in Q28, result Q1.15
    function automatic logic signed [SINE_BITS-1:0] sine_of_angle(input longint x);
        longint x2;
        longint term;
        longint sum;
        longint q;
        x2   = (x * x) / Q28_ONE;
        term = x;
        sum  = 0;
        for (int n = 0; n < TAYLOR_TERMS; n++)
        begin
            sum  = sum + term;
            term = -((term * x2) / Q28_ONE) / TAYLOR_DIV[n];
        end
        if (sum >= 0)
        begin
            q = (sum + Q15_HALF) / Q15_DIV;
        end
        else
        begin
            q = (sum - Q15_HALF) / Q15_DIV;
        end
        if (q > SINE_HI)
        begin
            q = SINE_HI;
        end
        if (q < SINE_LO)
        begin
            q = SINE_LO;
        end
        return SINE_BITS'(q);
    endfunction

endpackage

// ===== hw/rtl/sfid_ctrl.sv =====
module sfid_ctrl
    import sfid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output sfid_cmd_t cmd
);

    sfid_state_t state_reg;
    sfid_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_TAU;
                end
            end
            S_TAU:  state_next = S_ADDR;
            S_ADDR: state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_ACC;
            S_ACC:  state_next = S_GAIN;
            S_GAIN: state_next = S_MIX;
            S_MIX:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE: cmd.accept    = in_valid;
            S_TAU:  cmd.calc_tau  = 1'b1;
            S_ADDR: cmd.calc_addr = 1'b1;
            S_RD0:  cmd.rd_second = 1'b0;
            S_RD1:
            begin
                cmd.rd_second = 1'b1;
                cmd.latch_s0  = 1'b1;
            end
            S_ACC:  cmd.calc_acc  = 1'b1;
            S_GAIN: cmd.calc_gain = 1'b1;
            S_MIX:  cmd.load_out  = out_free;
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/sfid_datapath.sv =====
module sfid_datapath
    import sfid_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sfid_cmd_t                cmd,
    input  sfid_in_t                 in_data,
    output sfid_out_t                out_data,
    input  logic                     cfg_we,
    input  sfid_cfg_index_t          cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int TW  = $clog2(SINE_TABLE_DEPTH);
    localparam int STW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int DW  = AW + 8;
    localparam int CW  = (DW > TAU_BITS) ? DW : TAU_BITS;
    localparam logic [DW-1:0]  TAU_MAX   = DW'((HISTORY_DEPTH - 1) * 256);
    localparam logic [AW:0]    DEPTH_W   = (AW+1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0]  LAST_IDX  = AW'(HISTORY_DEPTH - 1);
    localparam logic [STW-1:0] SINE_N    = STW'(SINE_TABLE_DEPTH);

    // configuration
    logic [PHASE_BITS-1:0] step_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [GAIN_BITS-1:0]  gain_reg;

    // LFO and history bookkeeping
    logic [PHASE_BITS-1:0] phase_reg;
    logic [AW-1:0]         wi_reg;
    logic [AW:0]           fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= PHASE_STEP_RESET;
            depth_reg <= DEPTH_RESET;
            gain_reg  <= GAIN_RESET;
            phase_reg <= {START_PHASE_RESET, {(PHASE_BITS-START_BITS){1'b0}}};
            wi_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PHASE_STEP:  step_reg  <= cfg_data[PHASE_BITS-1:0];
                    CFG_START_PHASE: phase_reg <= {cfg_data[START_BITS-1:0],
                                                   {(PHASE_BITS-START_BITS){1'b0}}};
                    CFG_DEPTH:       depth_reg <= cfg_data[DEPTH_BITS-1:0];
                    CFG_GAIN:        gain_reg  <= cfg_data[GAIN_BITS-1:0];
                    default:         step_reg  <= step_reg;
                endcase
            end
            if (cmd.accept && (fill_reg != DEPTH_W))
            begin
                fill_reg <= fill_reg + (AW+1)'(1);
            end
            if (cmd.load_out)
            begin
                phase_reg <= phase_reg + step_reg;
                wi_reg    <= (wi_reg == LAST_IDX) ? '0 : wi_reg + AW'(1);
            end
        end
    end

    // sine table
    logic signed [SINE_BITS-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_sine
        localparam longint KK  = (2 * g <= SINE_TABLE_DEPTH) ? g : g - SINE_TABLE_DEPTH;
        localparam longint ANG = (KK * TWO_PI_Q28) / SINE_TABLE_DEPTH;
        assign sine_rom[g] = sine_of_angle(ANG);
    end

    logic [PHASE_BITS+STW-1:0]   tab_prod;
    logic [TW-1:0]               tab_idx;
    logic signed [SINE_BITS-1:0] sine_reg;

    assign tab_prod = {{STW{1'b0}}, phase_reg} * {{PHASE_BITS{1'b0}}, SINE_N};
    assign tab_idx  = tab_prod[PHASE_BITS +: TW];

    // tau = depth * (32768 + sine) >> 15, clamped to the store
    logic [SINE_BITS-1:0]            sine_bias;
    logic [DEPTH_BITS+SINE_BITS-1:0] tau_prod;
    logic [TAU_BITS-1:0]             tau_raw;
    logic [DW-1:0]                   tau_next;
    logic [DW-1:0]                   tau_reg;

    assign sine_bias = {~sine_reg[SINE_BITS-1], sine_reg[SINE_BITS-2:0]};
    assign tau_prod  = {{SINE_BITS{1'b0}}, depth_reg} * {{DEPTH_BITS{1'b0}}, sine_bias};
    assign tau_raw   = tau_prod[15 +: TAU_BITS];
    assign tau_next  = (CW'(tau_raw) > CW'(TAU_MAX)) ? TAU_MAX : DW'(tau_raw);

    // read addresses and whether each tap was ever written since reset
    logic [AW-1:0] whole;
    logic [7:0]    frac;
    logic [AW:0]   idx_diff;
    logic [AW:0]   idx_wrap;
    logic [AW-1:0] i0_next;
    logic [AW-1:0] i0_reg;
    logic [AW-1:0] i1_reg;
    logic          v0_reg;
    logic          v1_reg;

    assign whole    = tau_reg[DW-1:8];
    assign frac     = tau_reg[7:0];
    assign idx_diff = {1'b0, wi_reg} - {1'b0, whole};
    assign idx_wrap = idx_diff + DEPTH_W;
    assign i0_next  = idx_diff[AW] ? idx_wrap[AW-1:0] : idx_diff[AW-1:0];

    logic [AW-1:0] rd_addr;
    assign rd_addr = cmd.rd_second ? i1_reg : i0_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sine_reg <= sine_rom[tab_idx];
        end
        if (cmd.calc_tau)
        begin
            tau_reg <= tau_next;
        end
        if (cmd.calc_addr)
        begin
            i0_reg <= i0_next;
            i1_reg <= (i0_next == '0) ? LAST_IDX : i0_next - AW'(1);
            v0_reg <= ({1'b0, whole} < fill_reg);
            // a full-length delay lands the second tap on the current beat
            v1_reg <= (whole == LAST_IDX) || (({1'b0, whole} + (AW+1)'(1)) < fill_reg);
        end
    end

    // two channels, identical lanes
    logic signed [SAMPLE_BITS-1:0] lane_in  [2];
    logic signed [SAMPLE_BITS-1:0] lane_out [2];

    assign lane_in[0] = in_data.left_in;
    assign lane_in[1] = in_data.right_in;

    for (genvar c = 0; c < 2; c++)
    begin : g_lane
        logic signed [SAMPLE_BITS-1:0]   hist_mem [HISTORY_DEPTH];
        logic signed [SAMPLE_BITS-1:0]   rd_reg;
        logic signed [SAMPLE_BITS-1:0]   dry_reg;
        logic signed [SAMPLE_BITS-1:0]   s0_reg;
        logic signed [SAMPLE_BITS-1:0]   s1;
        logic signed [SAMPLE_BITS:0]     tap_diff;
        logic signed [8:0]               frac_s;
        logic signed [ACC_BITS-1:0]      acc_next;
        logic signed [ACC_BITS-1:0]      acc_reg;
        logic signed [WET_PROD_BITS-1:0] wet_prod;
        logic signed [WET_BITS-1:0]      wet_reg;
        logic signed [SUM_BITS-1:0]      sum;
        logic signed [SAMPLE_BITS-1:0]   sat;
        logic signed [SAMPLE_BITS-1:0]   out_reg;

        always_ff @(posedge clk)
        begin
            if (cmd.accept)
            begin
                hist_mem[wi_reg] <= lane_in[c];
            end
            rd_reg <= hist_mem[rd_addr];
        end

        assign s1       = v1_reg ? rd_reg : '0;
        assign tap_diff = (SAMPLE_BITS+1)'(s1) - (SAMPLE_BITS+1)'(s0_reg);
        assign frac_s   = $signed({1'b0, frac});
        assign acc_next = (ACC_BITS'(s0_reg) <<< 8) + ACC_BITS'(frac_s) * ACC_BITS'(tap_diff);
        assign wet_prod = WET_PROD_BITS'(acc_reg)
                        * WET_PROD_BITS'($signed({1'b0, gain_reg}));
        assign sum      = SUM_BITS'(dry_reg) + SUM_BITS'(wet_reg);

        always_comb
        begin
            if (sum > SUM_BITS'(SAMPLE_MAX))
            begin
                sat = SAMPLE_MAX;
            end
            else if (sum < SUM_BITS'(SAMPLE_MIN))
            begin
                sat = SAMPLE_MIN;
            end
            else
            begin
                sat = sum[SAMPLE_BITS-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.accept)
            begin
                dry_reg <= lane_in[c];
            end
            if (cmd.latch_s0)
            begin
                s0_reg <= v0_reg ? rd_reg : '0;
            end
            if (cmd.calc_acc)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.calc_gain)
            begin
                wet_reg <= $signed(wet_prod[WET_PROD_BITS-1:WET_SHIFT]);
            end
            if (cmd.load_out)
            begin
                out_reg <= sat;
            end
        end

        assign lane_out[c] = out_reg;
    end

    assign out_data.left_out  = lane_out[0];
    assign out_data.right_out = lane_out[1];

endmodule

// ===== hw/rtl/stereo_flanger_interp_delay_unit.sv =====
// Frames are taken one at a time: in_stall is high from the edge that accepts an input beat
// until the result is loaded into the output register, which can wait on out_stall. The
// controller steps each frame through sine lookup, delay calc, address calc, two history
// reads, interpolation, gain and mix.
// Reset (rst_n, async low): config registers take their defaults, LFO phase reloads,
// write pointer and fill count clear. History reads behind the fill count return zero,
// so no clearing pass is needed and a frame is taken right after reset.
module stereo_flanger_interp_delay_unit
    import sfid_pkg::*;
#(
    parameter int HISTORY_DEPTH    = 4096,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sfid_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output sfid_out_t                out_data,
    input  logic                     cfg_we,
    input  sfid_cfg_index_t          cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    sfid_cmd_t cmd;

    sfid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sfid_datapath #(
        .HISTORY_DEPTH    (HISTORY_DEPTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
